### design/dwes_pkg.sv
// Package for the dual wheel encoder speed unit.
// Holds the command codes, constants and transaction payload types.
// No dependencies.
`timescale 1ns / 1ps

package dwes_pkg;

	localparam logic [1:0] CMD_UPDATE     = 2'd0;
	localparam logic [1:0] CMD_CLR_LEFT   = 2'd1;
	localparam logic [1:0] CMD_CLR_RIGHT  = 2'd2;
	localparam logic [1:0] CMD_CLR_BOTH   = 2'd3;

	localparam int unsigned CPR_W = 14;
	localparam logic [CPR_W-1:0] CPR_RESET = 14'd1024;
	localparam logic [15:0] SPEED_SCALE = 16'd60000;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] left_raw_count;
		logic [15:0] right_raw_count;
		logic [15:0] sample_period;
	} dwes_cmd_t;

	typedef struct packed {
		logic signed [31:0] left_total;
		logic signed [31:0] right_total;
		logic signed [31:0] left_rpm;
		logic signed [31:0] right_rpm;
	} dwes_res_t;

endpackage

### design/dual_wheel_encoder_speed_unit.sv
// Top level of the dual wheel encoder speed unit.
// Uses dwes_pkg for command codes and payload types.
//
// Usage:
// A command transaction enters on cmd_valid/cmd_ready with cmd as payload.
// Each command yields one result transaction on res_valid/res_ready with
// both running totals and both held rpm values.
// The counts per revolution register is written through cfg_we/cfg_wdata;
// the user must write it only while the unit is idle, which the unit does
// not enforce. It takes effect at the next update. A clear command is
// applied at acceptance and passes through ST_DONE to res_valid. An update
// with a nonzero period and count runs per side ST_NUM to form the dividend,
// ST_DIV, where one shared restoring divider produces one quotient bit per
// cycle, 31 bits per side, and ST_FIX to apply the sign. An update with a
// zero period or count zeroes both rpm and goes to ST_DONE. cmd_ready is
// high only while no command is in work.
// A finished result sits in an output register, and a new command is
// accepted while it waits. If the receiver stalls, a second finished result
// waits in the sequencer until the register frees.
// Reset clears the last raw values, totals and held rpm to zero and sets the
// counts per revolution to 1024.
`timescale 1ns / 1ps

module dual_wheel_encoder_speed_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  dwes_pkg::dwes_cmd_t       cmd,
	output logic                      res_valid,
	input  logic                      res_ready,
	output dwes_pkg::dwes_res_t       res,
	input  logic                      cfg_we,
	input  logic [dwes_pkg::CPR_W-1:0] cfg_wdata
);

	import dwes_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NUM  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIX  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]       state_q;
	logic             side_q;
	logic [4:0]       cnt_q;
	logic [CPR_W-1:0] cpr_q;
	logic [15:0]      left_last_q;
	logic [15:0]      right_last_q;
	logic [31:0]      left_accum_q;
	logic [31:0]      right_accum_q;
	logic [31:0]      left_rpm_q;
	logic [31:0]      right_rpm_q;
	logic [15:0]      left_step_q;
	logic [15:0]      right_step_q;
	logic [29:0]      den_q;
	logic [29:0]      rem_q;
	logic [30:0]      num_q;
	logic             res_valid_q;
	dwes_res_t        res_q;

	logic        accept;
	logic        done_fire;
	logic [15:0] left_step;
	logic [15:0] right_step;
	logic [29:0] den_full;
	logic        zero_den;
	logic [15:0] cur_delta;
	logic        cur_neg;
	logic [15:0] cur_mag;
	logic [30:0] num_full;
	logic [30:0] shifted;
	logic [31:0] diff;
	logic        borrow;
	logic [31:0] q_ext;
	logic [31:0] rpm_val;
	logic        clr_left;
	logic        clr_right;

	assign accept      = cmd_valid && cmd_ready;
	assign cmd_ready   = (state_q == ST_IDLE);
	assign done_fire   = (state_q == ST_DONE) && (!res_valid_q || res_ready);
	assign left_step   = cmd.left_raw_count - left_last_q;
	assign right_step  = cmd.right_raw_count - right_last_q;
	assign den_full    = 30'(cmd.sample_period) * 30'(cpr_q);
	assign zero_den    = (cmd.sample_period == 16'd0) || (cpr_q == '0);
	assign clr_left    = (cmd.command == CMD_CLR_LEFT) || (cmd.command == CMD_CLR_BOTH);
	assign clr_right   = (cmd.command == CMD_CLR_RIGHT) || (cmd.command == CMD_CLR_BOTH);

	assign cur_delta = side_q ? right_step_q : left_step_q;
	assign cur_neg   = cur_delta[15];
	assign cur_mag   = cur_neg ? (~cur_delta + 16'd1) : cur_delta;
	assign num_full  = 31'(cur_mag) * 31'(SPEED_SCALE);

	assign shifted = {rem_q, num_q[30]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign borrow  = diff[31];

	assign q_ext   = {1'b0, num_q};
	assign rpm_val = cur_neg ? (~q_ext + 32'd1) : q_ext;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= CPR_RESET;
		end else if (cfg_we) begin
			cpr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			side_q        <= 1'b0;
			cnt_q         <= '0;
			left_last_q   <= '0;
			right_last_q  <= '0;
			left_accum_q  <= '0;
			right_accum_q <= '0;
			left_rpm_q    <= '0;
			right_rpm_q   <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (done_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.command == CMD_UPDATE) begin
							left_last_q   <= cmd.left_raw_count;
							right_last_q  <= cmd.right_raw_count;
							left_accum_q  <= left_accum_q + 32'(signed'(left_step));
							right_accum_q <= right_accum_q + 32'(signed'(right_step));
							if (zero_den) begin
								left_rpm_q  <= '0;
								right_rpm_q <= '0;
								state_q     <= ST_DONE;
							end else begin
								side_q  <= 1'b0;
								state_q <= ST_NUM;
							end
						end else begin
							state_q <= ST_DONE;
							if (clr_left) begin
								left_last_q  <= cmd.left_raw_count;
								left_accum_q <= '0;
								left_rpm_q   <= '0;
							end
							if (clr_right) begin
								right_last_q  <= cmd.right_raw_count;
								right_accum_q <= '0;
								right_rpm_q   <= '0;
							end
						end
					end
				end
				ST_NUM: begin
					cnt_q   <= 5'd30;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (side_q) begin
						right_rpm_q <= rpm_val;
						state_q     <= ST_DONE;
					end else begin
						left_rpm_q <= rpm_val;
						side_q     <= 1'b1;
						state_q    <= ST_NUM;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_step_q  <= left_step;
			right_step_q <= right_step;
			den_q        <= den_full;
		end
		if (state_q == ST_NUM) begin
			num_q <= num_full;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			num_q <= {num_q[29:0], ~borrow};
			rem_q <= borrow ? shifted[29:0] : diff[29:0];
		end
		if (done_fire) begin
			res_q.left_total  <= left_accum_q;
			res_q.right_total <= right_accum_q;
			res_q.left_rpm    <= left_rpm_q;
			res_q.right_rpm   <= right_rpm_q;
		end
	end

`ifndef ASSERT_OFF
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("command accepted but sequencer stayed idle");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && (cnt_q == 5'd0)) |=> (state_q == ST_FIX))
		else $error("divider did not finish after its last step");

	a_div_nonzero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != 30'd0))
		else $error("divider running with a zero divisor");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the completion step");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for dual_wheel_encoder_speed_unit.
// Drives command transactions, predicts totals and rpm in its own model and checks
// each result transaction; depends on dwes_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;

	import dwes_pkg::*;

	localparam int     STALL_LIMIT = 4000;
	localparam int     HOLD_CYCLES = 600;
	localparam int     PHASE_ITEMS = 100;
	localparam longint RPM_SCALE   = 60000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_ready;
	dwes_cmd_t        cmd = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	dwes_res_t        res;
	logic             cfg_we = 1'b0;
	logic [CPR_W-1:0] cfg_wdata = '0;

	dwes_cmd_t pending_cmds[$];
	dwes_res_t expected_res[$];

	logic [CPR_W-1:0] wheel_cpr = CPR_RESET;
	logic [15:0]      last_left = '0;
	logic [15:0]      last_right = '0;
	logic [31:0]      acc_left = '0;
	logic [31:0]      acc_right = '0;
	logic [31:0]      held_rpm_left = '0;
	logic [31:0]      held_rpm_right = '0;

	logic [15:0] gen_left = '0;
	logic [15:0] gen_right = '0;

	int  err_count = 0;
	int  res_count = 0;
	bit  cmd_taken = 1'b0;
	int  gap_left = 0;
	int  burst_left = 0;
	bit  hold_req = 1'b0;
	bit  hold_used = 1'b0;
	int  hold_left = 0;
	int  rdy_mode = 0;
	int  mode_left = 0;
	int  stall_cycles = 0;

	dual_wheel_encoder_speed_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] wrap_diff(input logic [15:0] now,
			input logic [15:0] last);
		logic [15:0] d;
		d = now - last;
		return {{16{d[15]}}, d};
	endfunction

	function automatic logic [31:0] rpm_of(input logic signed [31:0] delta,
			input logic [15:0] period);
		longint num;
		longint den;
		if (period == 16'd0 || wheel_cpr == '0) begin
			return 32'd0;
		end
		num = longint'(delta) * RPM_SCALE;
		den = longint'(wheel_cpr) * longint'(period);
		return 32'(num / den);
	endfunction

	task automatic apply_command(input dwes_cmd_t c);
		logic signed [31:0] dl;
		logic signed [31:0] dr;
		dwes_res_t r;
		if (c.command == CMD_UPDATE) begin
			dl = wrap_diff(c.left_raw_count, last_left);
			dr = wrap_diff(c.right_raw_count, last_right);
			last_left = c.left_raw_count;
			last_right = c.right_raw_count;
			acc_left = acc_left + dl;
			acc_right = acc_right + dr;
			held_rpm_left = rpm_of(dl, c.sample_period);
			held_rpm_right = rpm_of(dr, c.sample_period);
		end else begin
			if (c.command == CMD_CLR_LEFT || c.command == CMD_CLR_BOTH) begin
				last_left = c.left_raw_count;
				acc_left = '0;
				held_rpm_left = '0;
			end
			if (c.command == CMD_CLR_RIGHT || c.command == CMD_CLR_BOTH) begin
				last_right = c.right_raw_count;
				acc_right = '0;
				held_rpm_right = '0;
			end
		end
		r.left_total = acc_left;
		r.right_total = acc_right;
		r.left_rpm = held_rpm_left;
		r.right_rpm = held_rpm_right;
		expected_res.push_back(r);
	endtask

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("result %0d %s got %0d expected %0d",
				res_count, name, $signed(got), $signed(want)));
		end
	endtask

	task automatic push_cmd(input logic [1:0] op, input logic [15:0] l,
			input logic [15:0] r, input logic [15:0] p);
		dwes_cmd_t c;
		c.command = op;
		c.left_raw_count = l;
		c.right_raw_count = r;
		c.sample_period = p;
		if (op == CMD_UPDATE || op == CMD_CLR_LEFT || op == CMD_CLR_BOTH) begin
			gen_left = l;
		end
		if (op == CMD_UPDATE || op == CMD_CLR_RIGHT || op == CMD_CLR_BOTH) begin
			gen_right = r;
		end
		pending_cmds.push_back(c);
	endtask

	function automatic logic [15:0] raw_step();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 8));
			1: return 16'd0 - 16'($urandom_range(0, 300));
			2: return 16'($urandom_range(0, 4000)) - 16'd2000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] random_period();
		case ($urandom_range(0, 19))
			0: return 16'd0;
			1, 2, 3: return 16'($urandom);
			4, 5, 6, 7: return 16'($urandom_range(1, 2000));
			default: return 16'($urandom_range(1, 50));
		endcase
	endfunction

	task automatic push_random();
		int sel;
		logic [1:0] op;
		sel = $urandom_range(0, 99);
		if (sel < 75) begin
			op = CMD_UPDATE;
		end else if (sel < 83) begin
			op = CMD_CLR_LEFT;
		end else if (sel < 91) begin
			op = CMD_CLR_RIGHT;
		end else begin
			op = CMD_CLR_BOTH;
		end
		push_cmd(op, gen_left + raw_step(), gen_right + raw_step(), random_period());
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || expected_res.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_cpr(input logic [CPR_W-1:0] value);
		drain();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		wheel_cpr = value;
		@(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (cmd_valid && !cmd_taken) begin
			cmd_valid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left = gap_left - 1;
			cmd_valid <= 1'b0;
		end else if (pending_cmds.size() != 0) begin
			cmd_valid <= 1'b1;
			cmd <= pending_cmds[0];
			if (burst_left > 0) begin
				burst_left = burst_left - 1;
			end else begin
				burst_left = $urandom_range(0, 20);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end
		end else begin
			cmd_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cmd_taken = cmd_valid && cmd_ready;
		if (cmd_taken) begin
			apply_command(cmd);
			void'(pending_cmds.pop_front());
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end
			mode_left = mode_left - 1;
			case (rdy_mode)
				0: res_ready <= 1'b1;
				1: res_ready <= ($urandom_range(0, 1) == 1);
				default: res_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		dwes_res_t want;
		if (res_valid && res_ready) begin
			if (expected_res.size() == 0) begin
				report_error($sformatf("unexpected result transaction %0d", res_count));
			end else begin
				want = expected_res.pop_front();
				check_field("left_total", res.left_total, want.left_total);
				check_field("right_total", res.right_total, want.right_total);
				check_field("left_rpm", res.left_rpm, want.left_rpm);
				check_field("right_rpm", res.right_rpm, want.right_rpm);
			end
			res_count++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles = stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("dual_wheel_encoder_speed_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [CPR_W-1:0] cpr_val;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset value of the counts per revolution, clears of one side.
		push_cmd(CMD_UPDATE, 16'h0000, 16'h0000, 16'd1);
		push_cmd(CMD_UPDATE, 16'd100, 16'hFFFF, 16'd10);
		push_cmd(CMD_UPDATE, 16'h0000, 16'h0000, 16'd0);
		push_cmd(CMD_CLR_LEFT, 16'hAAAA, 16'h5555, 16'hFFFF);
		push_cmd(CMD_UPDATE, 16'hAAAB, 16'h5555, 16'hFFFF);
		push_cmd(CMD_CLR_RIGHT, 16'h1234, 16'hFFFF, 16'd7);
		push_cmd(CMD_CLR_BOTH, 16'h0000, 16'h0000, 16'd0);
		drain();

		// Largest deltas both ways with the smallest divisor.
		write_cpr(14'd1);
		push_cmd(CMD_UPDATE, 16'h7FFF, 16'h8000, 16'd1);
		push_cmd(CMD_UPDATE, 16'hFFFF, 16'h0000, 16'd1);
		push_cmd(CMD_UPDATE, 16'h7FFE, 16'h8001, 16'hFFFF);
		push_cmd(CMD_UPDATE, 16'h7FFE, 16'h8001, 16'd3);
		push_cmd(CMD_CLR_BOTH, 16'hFFFF, 16'hFFFF, 16'd9);
		push_cmd(CMD_UPDATE, 16'h0000, 16'hFFFE, 16'd1);

		write_cpr(14'd0);
		push_cmd(CMD_UPDATE, 16'h1000, 16'hF000, 16'd5);
		push_cmd(CMD_CLR_LEFT, 16'h00FF, 16'h0F0F, 16'd5);
		push_cmd(CMD_UPDATE, 16'h0000, 16'h0000, 16'd0);

		write_cpr(14'h3FFF);
		push_cmd(CMD_UPDATE, 16'h8FFF, 16'h7000, 16'd1);
		push_cmd(CMD_UPDATE, 16'h1FFF, 16'h0001, 16'hFFFF);
		push_cmd(CMD_UPDATE, 16'h1FFE, 16'h0002, 16'd1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cpr_val = 14'd1;
				1: cpr_val = 14'h3FFF;
				2: cpr_val = 14'd0;
				3: cpr_val = CPR_RESET;
				4: cpr_val = 14'($urandom_range(1, 64));
				default: cpr_val = 14'($urandom);
			endcase
			write_cpr(cpr_val);
			if (ph == 3) begin
				hold_req = 1'b1;
			end
			repeat (PHASE_ITEMS) push_random();
			drain();
		end

		repeat (80) @(posedge clk);
		if (expected_res.size() != 0) begin
			report_error($sformatf("%0d expected results never arrived",
				expected_res.size()));
		end
		if (err_count == 0) begin
			$display("dual_wheel_encoder_speed_unit verification clean");
		end else begin
			$display("dual_wheel_encoder_speed_unit verification failed");
		end
		$finish;
	end

endmodule
